// ===== hdl/cmv_pkg.sv =====
// Shared types and constants of the complex matrix-vector update block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package cmv_pkg;

  localparam int IDX_W       = 6;
  localparam int VAL_W       = 16;
  localparam int DIM_W       = 7;
  localparam int OPC_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam int PROD_W  = 32;
  localparam int TERM_W  = 33;
  localparam int ACC_W   = 40;
  localparam int SPLIT_W = 20;
  localparam int SUM_W   = 58;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [OPC_W-1:0] OPC_LOAD_MAT = 2'd0;
  localparam logic [OPC_W-1:0] OPC_LOAD_VEC = 2'd1;
  localparam logic [OPC_W-1:0] OPC_COMPUTE  = 2'd2;
  localparam logic [OPC_W-1:0] OPC_UNUSED   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 2'd2;

  localparam logic [DIM_W-1:0]        DIMENSION_RST = 7'd64;
  localparam logic signed [VAL_W-1:0] ALPHA_RST     = 16'sd16384;
  localparam logic signed [VAL_W-1:0] BETA_RST      = 16'sd0;

  typedef enum logic [1:0] {
    KIND_MAT = 2'd0,
    KIND_VEC = 2'd1,
    KIND_CMP = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t               kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [VAL_W-1:0]  re;
    logic signed [VAL_W-1:0]  im;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0]         dimension;
    logic signed [VAL_W-1:0]  alpha;
    logic signed [VAL_W-1:0]  beta;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/cmv_front.sv =====
// Front end: takes input beats, decodes the opcode and drops unused or out-of-store items.
// Depends on cmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmv_front #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [cmv_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic [cmv_pkg::OPC_W-1:0]         in_tuser,
  input  wire logic                              q_full,
  output logic                                   push,
  output cmv_pkg::item_t                         item
);

  logic row_ok;
  logic col_ok;
  logic keep;

  assign in_tready = !q_full;

  assign row_ok = int'(in_tdata[5:0]) < MAX_DIM;
  assign col_ok = int'(in_tdata[11:6]) < MAX_DIM;

  always_comb begin
    item.row = in_tdata[5:0];
    item.col = in_tdata[11:6];
    item.re  = $signed(in_tdata[27:12]);
    item.im  = $signed(in_tdata[43:28]);
    case (in_tuser)
      cmv_pkg::OPC_LOAD_MAT: begin
        item.kind = cmv_pkg::KIND_MAT;
        keep      = row_ok && col_ok;
      end
      cmv_pkg::OPC_LOAD_VEC: begin
        item.kind = cmv_pkg::KIND_VEC;
        keep      = row_ok;
      end
      cmv_pkg::OPC_COMPUTE: begin
        item.kind = cmv_pkg::KIND_CMP;
        keep      = 1'b1;
      end
      default: begin
        item.kind = cmv_pkg::KIND_CMP;
        keep      = 1'b0;
      end
    endcase
  end

  assign push = in_tvalid && in_tready && keep;

endmodule
`default_nettype wire

// ===== hdl/cmv_queue.sv =====
// Short item queue between the front end and the execution back end.
// Depends on cmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmv_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire cmv_pkg::item_t  item_in,
  input  wire logic            pop,
  output cmv_pkg::item_t       item_out,
  output cmv_pkg::q_ctl_t      ctl
);

  cmv_pkg::item_t                q_r [cmv_pkg::QDEPTH];
  logic [cmv_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [cmv_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [cmv_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign ctl.full  = cnt_r == cmv_pkg::QCNT_W'(cmv_pkg::QDEPTH);
  assign ctl.empty = cnt_r == '0;
  assign ctl.push  = do_push;
  assign ctl.pop   = do_pop;
  assign do_push   = push && !ctl.full;
  assign do_pop    = pop && !ctl.empty;
  assign item_out  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + cmv_pkg::QCNT_W'(do_push) - cmv_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cmv_back.sv =====
// Back end: matrix and vector stores, row multiply-accumulate, scaling, rounding, result register.
// Depends on cmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmv_back #(
  parameter int MAX_DIM   = 64,
  parameter int FRAC_BITS = 14
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cmv_pkg::cfg_t                     cfg,
  input  wire cmv_pkg::item_t                    item,
  input  wire cmv_pkg::q_ctl_t                   q_ctl,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [cmv_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tuser
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int SH = 2 * FRAC_BITS;
  localparam int HI_W = cmv_pkg::ACC_W - cmv_pkg::SPLIT_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MAC   = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_LO    = 7'b0001000,
    ST_HI    = 7'b0010000,
    ST_SUM   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] mat_mem [MAX_DIM * MAX_DIM];
  logic [31:0] vec_mem [MAX_DIM];
  logic [31:0] mat_rd_r, vec_rd_r;

  logic [AW-1:0]  base_r;
  logic [CW-1:0]  j_r, n_r, n_load;
  logic [5:0]     row_r;
  logic signed [15:0] yre_r, yim_r;
  logic           issue, rd_v_r, pr_v_r;
  logic           mat_we, vec_we, take;

  logic signed [cmv_pkg::PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [cmv_pkg::TERM_W-1:0] term_re, term_im;
  logic signed [cmv_pkg::ACC_W-1:0]  acc_re_r, acc_im_r;
  logic signed [36:0]                plo_re_r, plo_im_r;
  logic signed [35:0]                phi_re_r, phi_im_r;
  logic signed [31:0]                by_re_r, by_im_r;
  logic signed [cmv_pkg::SUM_W-1:0]  sum_re_r, sum_im_r;
  logic signed [cmv_pkg::SUM_W-1:0]  rnd_re, rnd_im, sh_re, sh_im;
  logic signed [15:0]                y_re, y_im;
  logic                              clip_re, clip_im, out_free;

  assign pop      = (state_r == ST_IDLE) && !q_ctl.empty;
  assign take     = pop;
  assign mat_we   = take && (item.kind == cmv_pkg::KIND_MAT);
  assign vec_we   = take && (item.kind == cmv_pkg::KIND_VEC);
  assign issue    = (state_r == ST_MAC) && (j_r < n_r);
  assign out_free = !out_tvalid || out_tready;

  assign n_load = (int'(item.row) >= MAX_DIM) ? '0 :
                  (int'(cfg.dimension) > MAX_DIM) ? CW'(MAX_DIM) : CW'(cfg.dimension);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (take && item.kind == cmv_pkg::KIND_CMP) begin
        state_nxt = ST_MAC;
      end
      ST_MAC:   if (!issue) begin
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: if (!rd_v_r && !pr_v_r) begin
        state_nxt = ST_LO;
      end
      ST_LO:    state_nxt = ST_HI;
      ST_HI:    state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_OUT;
      ST_OUT:   if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_v_r     <= 1'b0;
      pr_v_r     <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      pr_v_r  <= rd_v_r;
      if (state_r == ST_OUT && out_free) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[AW'(item.row) * AW'(MAX_DIM) + AW'(item.col)] <= {item.re, item.im};
    end
    if (vec_we) begin
      vec_mem[IW'(item.row)] <= {item.re, item.im};
    end
    mat_rd_r <= mat_mem[base_r + AW'(j_r)];
    vec_rd_r <= vec_mem[IW'(j_r)];
  end

  assign term_re = cmv_pkg::TERM_W'(p_rr_r) - cmv_pkg::TERM_W'(p_ii_r);
  assign term_im = cmv_pkg::TERM_W'(p_ri_r) + cmv_pkg::TERM_W'(p_ir_r);

  always_ff @(posedge clk) begin
    if (take) begin
      base_r   <= AW'(item.row) * AW'(MAX_DIM);
      row_r    <= item.row;
      yre_r    <= item.re;
      yim_r    <= item.im;
      n_r      <= n_load;
      j_r      <= '0;
      acc_re_r <= '0;
      acc_im_r <= '0;
    end
    if (issue) begin
      j_r <= j_r + 1'b1;
    end
    p_rr_r <= $signed(vec_rd_r[31:16]) * $signed(mat_rd_r[31:16]);
    p_ii_r <= $signed(vec_rd_r[15:0]) * $signed(mat_rd_r[15:0]);
    p_ri_r <= $signed(vec_rd_r[31:16]) * $signed(mat_rd_r[15:0]);
    p_ir_r <= $signed(vec_rd_r[15:0]) * $signed(mat_rd_r[31:16]);
    if (pr_v_r) begin
      acc_re_r <= acc_re_r + cmv_pkg::ACC_W'(term_re);
      acc_im_r <= acc_im_r + cmv_pkg::ACC_W'(term_im);
    end
    if (state_r == ST_LO) begin
      plo_re_r <= cfg.alpha * $signed({1'b0, acc_re_r[cmv_pkg::SPLIT_W-1:0]});
      plo_im_r <= cfg.alpha * $signed({1'b0, acc_im_r[cmv_pkg::SPLIT_W-1:0]});
      by_re_r  <= cfg.beta * yre_r;
      by_im_r  <= cfg.beta * yim_r;
    end
    if (state_r == ST_HI) begin
      phi_re_r <= cfg.alpha * $signed(acc_re_r[cmv_pkg::ACC_W-1 -: HI_W]);
      phi_im_r <= cfg.alpha * $signed(acc_im_r[cmv_pkg::ACC_W-1 -: HI_W]);
    end
    if (state_r == ST_SUM) begin
      sum_re_r <= (cmv_pkg::SUM_W'(phi_re_r) <<< cmv_pkg::SPLIT_W) + cmv_pkg::SUM_W'(plo_re_r)
                  + (cmv_pkg::SUM_W'(by_re_r) <<< FRAC_BITS);
      sum_im_r <= (cmv_pkg::SUM_W'(phi_im_r) <<< cmv_pkg::SPLIT_W) + cmv_pkg::SUM_W'(plo_im_r)
                  + (cmv_pkg::SUM_W'(by_im_r) <<< FRAC_BITS);
    end
    if (state_r == ST_OUT && out_free) begin
      out_tdata <= {2'b00, y_im, y_re, row_r};
      out_tuser <= clip_re || clip_im;
    end
  end

  always_comb begin
    rnd_re  = sum_re_r + (cmv_pkg::SUM_W'(1) <<< (SH - 1));
    rnd_im  = sum_im_r + (cmv_pkg::SUM_W'(1) <<< (SH - 1));
    sh_re   = rnd_re >>> SH;
    sh_im   = rnd_im >>> SH;
    clip_re = (sh_re > 32767) || (sh_re < -32768);
    clip_im = (sh_im > 32767) || (sh_im < -32768);
    y_re    = (sh_re > 32767) ? 16'sh7fff : (sh_re < -32768) ? 16'sh8000 : sh_re[15:0];
    y_im    = (sh_im > 32767) ? 16'sh7fff : (sh_im < -32768) ? 16'sh8000 : sh_im[15:0];
  end

endmodule
`default_nettype wire

// ===== hdl/complex_matrix_vector_axpby.sv =====
// Complex y = a*A*x + b*y block: configuration registers, front end, queue and back end.
// Depends on cmv_pkg, cmv_front, cmv_queue and cmv_back.
//
// Input channel in_*: one beat per item; in_tuser holds the opcode (load matrix entry,
// load x entry, compute y entry). Loads give no result; a compute beat gives one out_* beat.
// Configuration channel cfg_*: always ready; write while the block is idle.
// Beats enter a four-entry queue as soon as it has room; while the back end is idle, loads
// leave it at one per cycle. A compute item holds the back end while it works through n
// columns, n being the dimension in use (64 by default): one complex multiply-accumulate
// per column, paced by the single read port of the matrix store, then scaling, rounding
// and saturation. Results sit in an output register; while the receiver stalls the back end
// holds its finished result and the queue keeps taking beats until full.
// Synchronous reset clears control and restores dimension 64, a = 1.0, b = 0. The stores
// are not cleared; read only entries that were written.
`timescale 1ns / 1ps
`default_nettype none
module complex_matrix_vector_axpby #(
  parameter int MAX_DIM   = 64,
  parameter int FRAC_BITS = 14
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // row_index[5:0], column_index[11:6], value_re[27:12], value_im[43:28], zero pad
  input  wire logic [cmv_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode[1:0]
  input  wire logic [cmv_pkg::OPC_W-1:0]         in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_index[5:0], y_re[21:6], y_im[37:22], zero pad
  output logic [cmv_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // saturated[0]
  output logic                                   out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cmv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cmv_pkg::VAL_W-1:0]         cfg_data
);

  cmv_pkg::cfg_t   cfg_r;
  cmv_pkg::item_t  fe_item, q_item;
  cmv_pkg::q_ctl_t q_ctl;
  logic            fe_push, be_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dimension <= cmv_pkg::DIMENSION_RST;
      cfg_r.alpha     <= cmv_pkg::ALPHA_RST;
      cfg_r.beta      <= cmv_pkg::BETA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cmv_pkg::CFG_DIMENSION: cfg_r.dimension <= cfg_data[cmv_pkg::DIM_W-1:0];
        cmv_pkg::CFG_ALPHA:     cfg_r.alpha     <= $signed(cfg_data);
        cmv_pkg::CFG_BETA:      cfg_r.beta      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  cmv_front #(.MAX_DIM(MAX_DIM)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_ctl.full),
    .push      (fe_push),
    .item      (fe_item)
  );

  cmv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .item_in  (fe_item),
    .pop      (be_pop),
    .item_out (q_item),
    .ctl      (q_ctl)
  );

  cmv_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (q_item),
    .q_ctl      (q_ctl),
    .pop        (be_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== hdl/cmv_checker.sv =====
// Port-level checks of the complex matrix-vector update block, bound to the top level.
// Depends on complex_matrix_vector_axpby and cmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmv_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic [cmv_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              out_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat after reset");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[21:6] == 16'h7fff || out_tdata[21:6] == 16'h8000 ||
      out_tdata[37:22] == 16'h7fff || out_tdata[37:22] == 16'h8000)
    else $error("saturation flag without a clipped part");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:38] == 2'b00)
    else $error("result padding not zero");

endmodule

bind complex_matrix_vector_axpby cmv_checker u_cmv_checker (.*);
`default_nettype wire
